/* hw/rtl/glzw_pkg.sv */
package glzw_pkg;

    localparam int MaxCodeBitsDefault = 12;
    localparam int StackDepthDefault  = 4096;
    localparam int TableSize          = 4096;
    localparam int TableAw            = 12;

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_PULL  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    localparam logic [2:0] ST_PIXEL   = 3'd0;
    localparam logic [2:0] ST_TAKEN   = 3'd1;
    localparam logic [2:0] ST_NEED    = 3'd2;
    localparam logic [2:0] ST_REFUSED = 3'd3;
    localparam logic [2:0] ST_END     = 3'd4;
    localparam logic [2:0] ST_CORRUPT = 3'd5;
    localparam logic [2:0] ST_TRUNC   = 3'd6;
    localparam logic [2:0] ST_STARTED = 3'd7;

    typedef enum logic [1:0] {
        IMG_RUN,
        IMG_ENDED,
        IMG_BAD
    } img_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_POP,
        S_OUT
    } fsm_state_t;

    // table read and write request from the controller
    typedef struct packed {
        logic                wr_en;
        logic [TableAw-1:0]  wr_addr;
        logic [TableAw-1:0]  wr_prefix;
        logic [7:0]          wr_suffix;
        logic [TableAw-1:0]  rd_addr;
    } tbl_req_t;

endpackage

/* hw/rtl/glzw_tables.sv */
module glzw_tables (
    input  logic                clk,
    input  glzw_pkg::tbl_req_t  req,
    output logic [11:0]         rd_prefix,
    output logic [7:0]          rd_suffix
);
    import glzw_pkg::*;

    logic [TableAw-1:0] prefix_mem [TableSize];
    logic [7:0]         suffix_mem [TableSize];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            prefix_mem[req.wr_addr] <= req.wr_prefix;
            suffix_mem[req.wr_addr] <= req.wr_suffix;
        end
        rd_prefix <= prefix_mem[req.rd_addr];
        rd_suffix <= suffix_mem[req.rd_addr];
    end
endmodule

/* hw/rtl/glzw_stack.sv */
module glzw_stack #(
    parameter int STACK_DEPTH = glzw_pkg::StackDepthDefault,
    parameter int SAW = $clog2(STACK_DEPTH)
) (
    input  logic           clk,
    input  logic           wr_en,
    input  logic [SAW-1:0] wr_addr,
    input  logic [7:0]     wr_data,
    input  logic [SAW-1:0] rd_addr,
    output logic [7:0]     rd_data
);
    import glzw_pkg::*;

    logic [7:0] stack_mem [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_data <= stack_mem[rd_addr];
    end
endmodule

/* hw/rtl/gif_lzw_pixel_decoder_unit.sv */
// GIF LZW pixel decoder.
// Flow: byte, start and refused requests go from S_IDLE to S_OUT; a pull goes to S_DECIDE,
// then to S_POP to pop the stack, to S_OUT if no walk is needed (literal, end, no bits), or
// to S_WALK, alternating with S_POP to push each symbol of the chain; a clear repeats S_DECIDE.
// Throughput: one request in flight at a time; the next is taken once the result is taken.
// Reset (rst_n low, async) clears control state; tables and stack are not cleared.
module gif_lzw_pixel_decoder_unit #(
    parameter int MAX_CODE_BITS = glzw_pkg::MaxCodeBitsDefault,
    parameter int STACK_DEPTH   = glzw_pkg::StackDepthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,      // min_code_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic [1:0]  s_tuser,       // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // [7:0] pixel_index
    output logic [2:0]  m_tuser        // [2:0] status
);
    import glzw_pkg::*;

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = SAW + 1;
    localparam logic [12:0] TABLE_LIM = 13'(1) << MAX_CODE_BITS;
    localparam logic [SPW-1:0] SDEPTH = SPW'(STACK_DEPTH);

    fsm_state_t state_reg, state_next;
    img_state_t img_reg, img_next;

    logic [3:0]  cfg_min_reg;
    logic [3:0]  min_reg, min_next;
    logic [23:0] acc_reg, acc_next;
    logic [4:0]  held_reg, held_next;
    logic [3:0]  cw_reg, cw_next;
    logic [12:0] nfc_reg, nfc_next;
    logic [12:0] lim_reg, lim_next;
    logic [11:0] prev_reg, prev_next;
    logic [7:0]  first_reg, first_next;
    logic        fresh_reg, fresh_next;
    logic [7:0]  sub_reg, sub_next;
    logic        done_reg, done_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [11:0] code_reg, code_next;   // chain walk cursor
    logic [11:0] inc_reg, inc_next;     // incoming code of the walk
    logic        mode_pull_reg;
    logic [7:0]  pix_reg, pix_next;
    logic [2:0]  st_reg, st_next;
    logic        ov_reg;

    tbl_req_t    treq;
    logic [11:0] t_prefix;
    logic [7:0]  t_suffix;
    logic        s_wr;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [7:0]  s_wdata, s_rdata;

    glzw_tables u_tab (
        .clk(clk), .req(treq), .rd_prefix(t_prefix), .rd_suffix(t_suffix)
    );

    glzw_stack #(.STACK_DEPTH(STACK_DEPTH), .SAW(SAW)) u_stk (
        .clk(clk), .wr_en(s_wr), .wr_addr(s_waddr), .wr_data(s_wdata),
        .rd_addr(s_raddr), .rd_data(s_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE) && !ov_reg;
    assign m_tvalid  = ov_reg;
    assign m_tdata   = pix_reg;
    assign m_tuser   = st_reg;

    wire       acc_in = s_tvalid && s_tready;
    wire [1:0] in_mode = s_tuser;
    wire [7:0] in_byte = s_tdata;

    logic [12:0] clr;
    logic [11:0] code;
    logic [11:0] cmask;
    logic [3:0]  mclamp;

    always_comb
    begin
        clr   = 13'(1) << min_reg;
        cmask = 12'((13'(1) << cw_reg) - 13'd1);
        code  = acc_reg[11:0] & cmask;
        mclamp = (cfg_min_reg < 4'd2) ? 4'd2 : ((cfg_min_reg > 4'd8) ? 4'd8 : cfg_min_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        img_next = img_reg;
        min_next = min_reg;
        acc_next = acc_reg;
        held_next = held_reg;
        cw_next = cw_reg;
        nfc_next = nfc_reg;
        lim_next = lim_reg;
        prev_next = prev_reg;
        first_next = first_reg;
        fresh_next = fresh_reg;
        sub_next = sub_reg;
        done_next = done_reg;
        sp_next = sp_reg;
        code_next = code_reg;
        inc_next = inc_reg;
        pix_next = pix_reg;
        st_next = st_reg;
        treq = '0;
        treq.rd_addr = code_reg;
        s_wr = 1'b0;
        s_waddr = sp_reg[SAW-1:0];
        s_wdata = 8'd0;
        s_raddr = SAW'(sp_reg - SPW'(1));

        case (state_reg)
            S_IDLE:
            begin
                if (acc_in)
                begin
                    pix_next = 8'd0;
                    state_next = S_OUT;
                    case (in_mode)
                        MODE_BYTE:
                        begin
                            if (done_reg)
                            begin
                                st_next = ST_REFUSED;
                            end
                            else if (sub_reg == 8'd0)
                            begin
                                st_next = ST_TAKEN;
                                if (in_byte == 8'd0)
                                begin
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    sub_next = in_byte;
                                end
                            end
                            else if (img_reg == IMG_RUN && held_reg > 5'd16)
                            begin
                                st_next = ST_REFUSED;
                            end
                            else
                            begin
                                st_next = ST_TAKEN;
                                sub_next = sub_reg - 8'd1;
                                if (img_reg == IMG_RUN)
                                begin
                                    acc_next = acc_reg | (24'(in_byte) << held_reg);
                                    held_next = held_reg + 5'd8;
                                end
                            end
                        end
                        MODE_PULL:
                        begin
                            state_next = S_DECIDE;
                        end
                        MODE_START:
                        begin
                            st_next = ST_STARTED;
                            min_next = mclamp;
                            cw_next = mclamp + 4'd1;
                            nfc_next = (13'(1) << mclamp) + 13'd2;
                            lim_next = 13'(2) << mclamp;
                            sp_next = '0;
                            acc_next = '0;
                            held_next = '0;
                            prev_next = '0;
                            first_next = '0;
                            fresh_next = 1'b1;
                            sub_next = '0;
                            done_next = 1'b0;
                            img_next = IMG_RUN;
                        end
                        default:
                        begin
                            st_next = ST_REFUSED;
                        end
                    endcase
                end
            end
            S_DECIDE:
            begin
                state_next = S_OUT;
                if (sp_reg > '0 && sp_reg <= SDEPTH)
                begin
                    sp_next = sp_reg - SPW'(1);
                    state_next = S_POP;
                end
                else if (img_reg == IMG_ENDED)
                begin
                    sp_next = '0;
                    st_next = ST_END;
                end
                else if (img_reg == IMG_BAD)
                begin
                    sp_next = '0;
                    st_next = ST_CORRUPT;
                end
                else if (held_reg < 5'(cw_reg))
                begin
                    sp_next = '0;
                    st_next = done_reg ? ST_TRUNC : ST_NEED;
                end
                else
                begin
                    sp_next = '0;
                    acc_next = acc_reg >> cw_reg;
                    held_next = held_reg - 5'(cw_reg);
                    if (13'(code) == clr)
                    begin
                        cw_next = min_reg + 4'd1;
                        nfc_next = clr + 13'd2;
                        lim_next = clr << 1;
                        fresh_next = 1'b1;
                        state_next = S_DECIDE;
                    end
                    else if (13'(code) == clr + 13'd1)
                    begin
                        img_next = IMG_ENDED;
                        st_next = ST_END;
                    end
                    else if (fresh_reg)
                    begin
                        if (13'(code) >= clr)
                        begin
                            img_next = IMG_BAD;
                            st_next = ST_CORRUPT;
                        end
                        else
                        begin
                            fresh_next = 1'b0;
                            first_next = code[7:0];
                            prev_next = code;
                            pix_next = code[7:0];
                            st_next = ST_PIXEL;
                        end
                    end
                    else if (13'(code) > nfc_reg)
                    begin
                        img_next = IMG_BAD;
                        st_next = ST_CORRUPT;
                    end
                    else
                    begin
                        inc_next = code;
                        code_next = code;
                        state_next = S_WALK;
                        if (13'(code) == nfc_reg)
                        begin
                            s_wr = 1'b1;
                            s_waddr = '0;
                            s_wdata = first_reg;
                            sp_next = SPW'(1);
                            code_next = prev_reg;
                        end
                    end
                end
            end
            S_WALK:
            begin
                // table read for code_reg issued here; data arrives in S_POP
                treq.rd_addr = code_reg;
                if (sp_reg >= SDEPTH)
                begin
                    img_next = IMG_BAD;
                    sp_next = '0;
                    pix_next = 8'd0;
                    st_next = ST_CORRUPT;
                    state_next = S_OUT;
                end
                else if (13'(code_reg) >= clr)
                begin
                    // move to S_POP, where the registered table read data is valid
                    state_next = S_POP;
                    st_next = ST_PIXEL;
                    pix_next = 8'd1; // marks walk read pending
                end
                else
                begin
                    s_wr = 1'b1;
                    s_wdata = code_reg[7:0];
                    sp_next = sp_reg + SPW'(1);
                    first_next = code_reg[7:0];
                    if (nfc_reg < TABLE_LIM)
                    begin
                        treq.wr_en = 1'b1;
                        treq.wr_addr = nfc_reg[11:0];
                        treq.wr_prefix = prev_reg;
                        treq.wr_suffix = code_reg[7:0];
                        nfc_next = nfc_reg + 13'd1;
                        if (nfc_reg + 13'd1 >= lim_reg && lim_reg < TABLE_LIM)
                        begin
                            lim_next = lim_reg << 1;
                            cw_next = cw_reg + 4'd1;
                        end
                    end
                    prev_next = inc_reg;
                    state_next = S_DECIDE;
                end
            end
            S_POP:
            begin
                if (pix_reg == 8'd1 && st_reg == ST_PIXEL && mode_pull_reg)
                begin
                    // walk step: read data valid for code_reg
                    s_wr = 1'b1;
                    s_wdata = t_suffix;
                    sp_next = sp_reg + SPW'(1);
                    code_next = t_prefix;
                    treq.rd_addr = t_prefix;
                    pix_next = 8'd0;
                    state_next = S_WALK;
                end
                else
                begin
                    s_raddr = sp_reg[SAW-1:0];
                    pix_next = s_rdata;
                    st_next = ST_PIXEL;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // mode_pull_reg tells S_POP apart: set while in a walk, clear for a pop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_pull_reg <= 1'b0;
        end
        else if (state_reg == S_WALK && state_next == S_POP)
        begin
            mode_pull_reg <= 1'b1;
        end
        else if (state_reg == S_POP || state_reg == S_DECIDE)
        begin
            mode_pull_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            img_reg <= IMG_RUN;
            cfg_min_reg <= 4'd8;
            min_reg <= 4'd8;
            acc_reg <= '0;
            held_reg <= '0;
            cw_reg <= 4'd9;
            nfc_reg <= 13'd258;
            lim_reg <= 13'd512;
            prev_reg <= '0;
            first_reg <= '0;
            fresh_reg <= 1'b1;
            sub_reg <= '0;
            done_reg <= 1'b0;
            sp_reg <= '0;
            code_reg <= '0;
            inc_reg <= '0;
            pix_reg <= '0;
            st_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cfg_min_reg <= cfg_data;
            end
            state_reg <= state_next;
            img_reg <= img_next;
            min_reg <= min_next;
            acc_reg <= acc_next;
            held_reg <= held_next;
            cw_reg <= cw_next;
            nfc_reg <= nfc_next;
            lim_reg <= lim_next;
            prev_reg <= prev_next;
            first_reg <= first_next;
            fresh_reg <= fresh_next;
            sub_reg <= sub_next;
            done_reg <= done_next;
            sp_reg <= sp_next;
            code_reg <= code_next;
            inc_reg <= inc_next;
            pix_reg <= pix_next;
            st_reg <= st_next;
            if (state_reg == S_OUT)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // no new request while a result waits
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("request accepted with result pending");
    // result appears only from the output step
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT)) else $error("stray result");
    // stack pointer never exceeds depth
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SDEPTH) else $error("stack pointer out of range");
endmodule
